/* design/anag_pkg.sv */
// Shared types and default constants for the anagram group classifier.
`timescale 1ns / 1ps
package anag_pkg;

  localparam int MAX_GROUPS_DEF    = 64;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int COUNT_BITS_DEF    = 7;

  // Fixed field widths of the ports.
  localparam int LETTER_W    = 5;
  localparam int GROUP_IDX_W = 6;

  // Control broadcast from the sequencer to every letter cell.
  typedef struct packed {
    logic                inc;     // count a letter this cycle
    logic [LETTER_W-1:0] letter;  // which letter
    logic                clear;   // word done, zero the histogram
  } cell_ctrl_t;

endpackage

/* design/anag_cell.sv */
// One letter cell: a saturating count and its slice of the signature compare.
`timescale 1ns / 1ps
module anag_cell #(
  parameter int COUNT_BITS = anag_pkg::COUNT_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  anag_pkg::cell_ctrl_t  ctrl,
  input  logic [COUNT_BITS-1:0] sig,     // stored count for this letter
  input  logic                  eq_in,   // all earlier cells matched
  output logic                  eq_out,
  output logic [COUNT_BITS-1:0] count
);

  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  hit;

  assign hit = ctrl.inc && (32'(ctrl.letter) == INDEX);

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (hit && (count_r != {COUNT_BITS{1'b1}})) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign eq_out = eq_in && (sig == count_r);
  assign count  = count_r;

endmodule

/* design/anag_sig_store.sv */
// Group signature memory: one row of packed letter counts per group.
`timescale 1ns / 1ps
module anag_sig_store #(
  parameter int DEPTH = anag_pkg::MAX_GROUPS_DEF,
  parameter int AW    = 6,
  parameter int DW    = anag_pkg::ALPHABET_SIZE_DEF * anag_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/anagram_group_classifier_top.sv */
// Top level: letter cell chain, signature memory and word-end search sequencer.
// A beat that does not end a word leaves busy low; start is taken again next cycle.
// Word end: one stored group is read per cycle and compared against the histogram; out_valid
//   strobes on the first match or, if none matches, with a new group or the table-full flag.
// Busy stays high through the search, so no new beat is taken until it ends; receiver cannot stall.
// Reset (rst_n low, synchronous): histogram, group count, sequencer cleared; memory is not.
`timescale 1ns / 1ps
module anagram_group_classifier_top #(
  parameter int MAX_GROUPS    = anag_pkg::MAX_GROUPS_DEF,
  parameter int ALPHABET_SIZE = anag_pkg::ALPHABET_SIZE_DEF,
  parameter int COUNT_BITS    = anag_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beats
  input  logic                             start,
  output logic                             busy,
  input  logic [anag_pkg::LETTER_W-1:0]    in_letter,
  input  logic                             in_has_letter,
  input  logic                             in_last_of_word,
  // result beats
  output logic                             out_valid,
  output logic [anag_pkg::GROUP_IDX_W-1:0] out_group_index,
  output logic                             out_new_group,
  output logic                             out_table_full
);

  // Group count holds 0..MAX_GROUPS; memory address covers 0..MAX_GROUPS-1.
  localparam int GU_W = $clog2(MAX_GROUPS + 1);
  localparam int AW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int DW   = ALPHABET_SIZE * COUNT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [GU_W-1:0] groups_used_r, groups_used_nxt;
  logic [GU_W-1:0] issue_r, issue_nxt;       // next group to read
  logic [GU_W-1:0] pend_g_r, pend_g_nxt;     // group whose row is in rdata
  logic            pend_vld_r, pend_vld_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [anag_pkg::GROUP_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                             out_new_r, out_new_nxt;
  logic                             out_full_r, out_full_nxt;

  logic                 accept;
  logic                 mem_we;
  logic                 clear;
  logic [DW-1:0]        hist;      // packed live histogram
  logic [DW-1:0]        sig_row;   // stored row under compare
  logic [ALPHABET_SIZE:0] eq_chain;
  anag_pkg::cell_ctrl_t cell_ctrl;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Broadcast to the cells: count on accepted letter beats, clear on word end.
  assign cell_ctrl.inc    = accept && in_has_letter;
  assign cell_ctrl.letter = in_letter;
  assign cell_ctrl.clear  = clear;

  // Cell row. The equality term ripples cell to cell; out-of-range letters hit no cell.
  assign eq_chain[0] = 1'b1;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    anag_cell #(
      .COUNT_BITS (COUNT_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (cell_ctrl),
      .sig    (sig_row[i*COUNT_BITS +: COUNT_BITS]),
      .eq_in  (eq_chain[i]),
      .eq_out (eq_chain[i+1]),
      .count  (hist[i*COUNT_BITS +: COUNT_BITS])
    );
  end

  anag_sig_store #(
    .DEPTH (MAX_GROUPS),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (groups_used_r[AW-1:0]),
    .wdata (hist),
    .raddr (issue_r[AW-1:0]),
    .rdata (sig_row)
  );

  // Sequencer. In search, one row is read per cycle and the row read the cycle
  // before is compared against the histogram.
  always_comb begin
    state_nxt       = state_r;
    groups_used_nxt = groups_used_r;
    issue_nxt       = issue_r;
    pend_g_nxt      = pend_g_r;
    pend_vld_nxt    = pend_vld_r;
    out_valid_nxt   = 1'b0;
    out_idx_nxt     = out_idx_r;
    out_new_nxt     = out_new_r;
    out_full_nxt    = out_full_r;
    mem_we          = 1'b0;
    clear           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_last_of_word) begin
          state_nxt    = ST_SEARCH;
          issue_nxt    = '0;
          pend_vld_nxt = 1'b0;
        end
      end

      ST_SEARCH: begin
        if (pend_vld_r && eq_chain[ALPHABET_SIZE]) begin
          // match: report the stored group
          state_nxt     = ST_IDLE;
          clear         = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = anag_pkg::GROUP_IDX_W'(pend_g_r);
          out_new_nxt   = 1'b0;
          out_full_nxt  = 1'b0;
        end else if (issue_r < groups_used_r) begin
          issue_nxt    = issue_r + GU_W'(1);
          pend_g_nxt   = issue_r;
          pend_vld_nxt = 1'b1;
        end else if (pend_vld_r) begin
          // last row mismatched, drain
          pend_vld_nxt = 1'b0;
        end else begin
          // no match anywhere
          state_nxt     = ST_IDLE;
          clear         = 1'b1;
          out_valid_nxt = 1'b1;
          if (groups_used_r < GU_W'(MAX_GROUPS)) begin
            mem_we          = 1'b1;
            groups_used_nxt = groups_used_r + GU_W'(1);
            out_idx_nxt     = anag_pkg::GROUP_IDX_W'(groups_used_r);
            out_new_nxt     = 1'b1;
            out_full_nxt    = 1'b0;
          end else begin
            out_idx_nxt  = '0;
            out_new_nxt  = 1'b0;
            out_full_nxt = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      groups_used_r <= '0;
      pend_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      groups_used_r <= groups_used_nxt;
      pend_vld_r    <= pend_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    issue_r    <= issue_nxt;
    pend_g_r   <= pend_g_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_group_index = out_idx_r;
  assign out_new_group   = out_new_r;
  assign out_table_full  = out_full_r;

  // Checks

  // A result beat only follows a search cycle.
  a_out_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_SEARCH))
    else $error("result beat without a search");

  // Leaving the search always produces exactly the result beat.
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid_r)
    else $error("search ended without a result beat");

  // The group count never passes the table size.
  a_groups_bound: assert property (@(posedge clk) disable iff (!rst_n)
    groups_used_r <= GU_W'(MAX_GROUPS))
    else $error("group count past table size");

  // A new group advances the group count by one.
  a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_new_r) |-> (groups_used_r == $past(groups_used_r) + GU_W'(1)))
    else $error("new group without count advance");

  // A new group and a full table never come together.
  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_full_r))
    else $error("new group reported with full table");

endmodule
